>>> hw/rtl/hsct_pkg.sv
// ----------------------------------------------------------------------------
// hsct_pkg: shared constants and types of the harmonic sine/cosine table
// Widths, CORDIC constants and fixed-point helpers.
// ----------------------------------------------------------------------------
package hsct_pkg;
	localparam int ANGLE_BITS = 16;
	localparam int FRAC_BITS = 16;
	localparam int OUT_BITS = FRAC_BITS + 2;
	localparam int CORDIC_STEPS = 16;
	localparam int STEP_BITS = 4;
	localparam int HARM_BITS = 6;
	localparam int NFP_BITS = 8;
	localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
	localparam logic signed [OUT_BITS-1:0] ONE_Q = OUT_BITS'(1) << FRAC_BITS;

	localparam logic [1:0] REG_MAX_M = 2'd0;
	localparam logic [1:0] REG_MAX_N = 2'd1;
	localparam logic [1:0] REG_NFP = 2'd2;

	typedef logic signed [OUT_BITS-1:0] trig_t;

	function automatic logic signed [33:0] atan_turn(input logic [STEP_BITS-1:0] i);
		case (i)
			4'd0: atan_turn = 34'sd536870912;
			4'd1: atan_turn = 34'sd316933406;
			4'd2: atan_turn = 34'sd167458907;
			4'd3: atan_turn = 34'sd85004756;
			4'd4: atan_turn = 34'sd42667331;
			4'd5: atan_turn = 34'sd21354465;
			4'd6: atan_turn = 34'sd10679838;
			4'd7: atan_turn = 34'sd5340245;
			4'd8: atan_turn = 34'sd2670163;
			4'd9: atan_turn = 34'sd1335087;
			4'd10: atan_turn = 34'sd667544;
			4'd11: atan_turn = 34'sd333772;
			4'd12: atan_turn = 34'sd166886;
			4'd13: atan_turn = 34'sd83443;
			4'd14: atan_turn = 34'sd41722;
			default: atan_turn = 34'sd20861;
		endcase
	endfunction

	// Saturate a wide signed value to plus or minus one.
	function automatic trig_t sat_one(input logic signed [47:0] v);
		logic signed [47:0] one;
		one = 48'sd1 <<< FRAC_BITS;
		if (v > one) sat_one = ONE_Q;
		else if (v < -one) sat_one = -ONE_Q;
		else sat_one = OUT_BITS'(v);
	endfunction
endpackage

>>> hw/rtl/harmonic_sincos_table_core.sv
// ----------------------------------------------------------------------------
// harmonic_sincos_table_core: harmonics of cos and sin for one grid point
// One shared CORDIC datapath and one shared rotation multiplier under a
// small sequencer.
// ----------------------------------------------------------------------------
// A request on s_axis carries theta (bits 15:0) and zeta (bits 31:16). On
// acceptance the block scales zeta by field_periods. It runs a 16-step
// CORDIC for theta and then for the scaled zeta, one micro-rotation per cycle.
// Each angle goes through one load step, 16 iterations and one capture step.
// After both angles it emits harmonic 0. It then emits one result per
// harmonic k up to max(max_m, max_n) on m_axis, and tlast marks the final
// one. Each harmonic after zero goes through four multiply phases of the
// shared multiplier (new cos and sin for theta and for zeta), one step to
// round the last sum and one emit step. s_axis_tready is high only while the
// block is idle. A stall on m_axis holds the pending result in the output
// register. The sequencer then waits in its emit step. Reset aborts any grid
// point and loads the register defaults (max_m 4, max_n 4, field_periods 1).
// Registers are written through cfg_we, cfg_index and cfg_data; the user
// must write them only while idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module harmonic_sincos_table_core (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// tdata: theta_angle[15:0], zeta_angle[31:16]
	input  logic [31:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// tdata: harmonic_index[5:0], cos_m_theta[23:6], sin_m_theta[41:24],
	// cos_n_zeta[59:42], sin_n_zeta[77:60], zero fill [79:78]
	output logic [79:0] m_axis_tdata,
	// tuser: m_valid[0], n_valid[1]
	output logic [1:0] m_axis_tuser,
	output logic m_axis_tlast
);
	import hsct_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CORD = 3'd1;
	localparam logic [2:0] ST_FIN = 3'd2;
	localparam logic [2:0] ST_MUL = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;
	localparam logic [2:0] ST_RND = 3'd5;

	logic [2:0] state_q;
	logic [HARM_BITS-1:0] max_m_q, max_n_q, k_q, top_q;
	logic [NFP_BITS-1:0] nfp_q;
	logic [ANGLE_BITS-1:0] zeta_q, theta_q;
	logic which_q; // 0 theta, 1 zeta
	logic [STEP_BITS-1:0] step_q;
	logic [1:0] quad_q, mph_q;
	logic signed [33:0] x_q, y_q, z_q;
	trig_t cm1_q, sm1_q, cn1_q, sn1_q, cm_q, sm_q, cn_q, sn_q;
	logic signed [47:0] acc_q;

	// CORDIC preparation of an angle.
	logic [ANGLE_BITS-1:0] ang_sel;
	logic [31:0] a32, d32;
	logic [1:0] qd;
	assign ang_sel = which_q ? zeta_q : theta_q;
	assign a32 = {ang_sel, {(32 - ANGLE_BITS){1'b0}}};
	assign qd = 2'((a32 + 32'h2000_0000) >> 30);
	assign d32 = a32 - {qd, 30'd0};

	logic signed [33:0] xs, ys, at;
	assign xs = x_q >>> step_q;
	assign ys = y_q >>> step_q;
	assign at = atan_turn(step_q);

	localparam int SH = 30 - FRAC_BITS;
	trig_t cx, sy, qc, qs;
	assign cx = sat_one(48'((48'(x_q) + (48'sd1 <<< (SH - 1))) >>> SH));
	assign sy = sat_one(48'((48'(y_q) + (48'sd1 <<< (SH - 1))) >>> SH));
	always_comb begin
		case (quad_q)
			2'd0: begin qc = cx; qs = sy; end
			2'd1: begin qc = -sy; qs = cx; end
			2'd2: begin qc = -cx; qs = -sy; end
			default: begin qc = sy; qs = -cx; end
		endcase
	end

	// Shared multiplier: phases 0..3 = new cm, new sm, new cn, new sn.
	trig_t ma, mb, mc, md;
	always_comb begin
		case (mph_q)
			2'd0: begin ma = cm_q; mb = cm1_q; mc = sm_q; md = -sm1_q; end
			2'd1: begin ma = sm_q; mb = cm1_q; mc = cm_q; md = sm1_q; end
			2'd2: begin ma = cn_q; mb = cn1_q; mc = sn_q; md = -sn1_q; end
			default: begin ma = sn_q; mb = cn1_q; mc = cn_q; md = sn1_q; end
		endcase
	end
	logic signed [35:0] prod_a, prod_b;
	logic signed [47:0] prod_sum;
	trig_t rnd;
	assign prod_a = ma * mb;
	assign prod_b = mc * md;
	assign prod_sum = 48'(prod_a) + 48'(prod_b);
	assign rnd = sat_one((acc_q + (48'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);

	// Payload captured with the request.
	logic [ANGLE_BITS+NFP_BITS-1:0] zprod;
	assign zprod = s_axis_tdata[31:16] * nfp_q;

	logic out_free;
	assign out_free = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			max_m_q <= 6'd4;
			max_n_q <= 6'd4;
			nfp_q <= 8'd1;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_M: max_m_q <= cfg_data[HARM_BITS-1:0];
					REG_MAX_N: max_n_q <= cfg_data[HARM_BITS-1:0];
					REG_NFP: nfp_q <= cfg_data;
					default: ;
				endcase
			end
			// The emit step reloads the output register itself.
			if (m_axis_tvalid && m_axis_tready && state_q != ST_EMIT)
				m_axis_tvalid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						theta_q <= s_axis_tdata[15:0];
						zeta_q <= zprod[ANGLE_BITS-1:0];
						which_q <= 1'b0;
						top_q <= (max_m_q > max_n_q) ? max_m_q : max_n_q;
						state_q <= ST_FIN;
						mph_q <= 2'd3; // marks a fresh angle load
					end
				end
				ST_CORD: begin
					if (z_q >= 0) begin
						x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - at;
					end else begin
						x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + at;
					end
					step_q <= step_q + 4'd1;
					if (step_q == 4'(CORDIC_STEPS - 1)) begin
						state_q <= ST_FIN;
						mph_q <= 2'd0;
					end
				end
				ST_FIN: begin
					if (mph_q == 2'd3) begin
						// Load the angle and start the iterations.
						x_q <= GAIN_Q30;
						y_q <= '0;
						z_q <= 34'($signed(d32));
						quad_q <= qd;
						step_q <= '0;
						state_q <= ST_CORD;
					end else if (!which_q) begin
						cm1_q <= qc; sm1_q <= qs;
						which_q <= 1'b1;
						mph_q <= 2'd3;
					end else begin
						cn1_q <= qc; sn1_q <= qs;
						cm_q <= ONE_Q; sm_q <= '0; cn_q <= ONE_Q; sn_q <= '0;
						k_q <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_MUL: begin
					// acc_q holds the previous phase's sum; commit it.
					acc_q <= prod_sum;
					mph_q <= mph_q + 2'd1;
					case (mph_q)
						2'd0: ;
						2'd1: cm_q <= rnd;
						2'd2: sm_q <= rnd;
						default: begin
							cn_q <= rnd;
							state_q <= ST_RND;
						end
					endcase
				end
				ST_RND: begin
					sn_q <= rnd;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tdata <= {2'b00,
							(k_q <= max_n_q) ? sn_q : trig_t'(0),
							(k_q <= max_n_q) ? cn_q : trig_t'(0),
							(k_q <= max_m_q) ? sm_q : trig_t'(0),
							(k_q <= max_m_q) ? cm_q : trig_t'(0), k_q};
						m_axis_tuser <= {k_q <= max_n_q, k_q <= max_m_q};
						m_axis_tlast <= (k_q == top_q);
						if (k_q == top_q) state_q <= ST_IDLE;
						else begin
							k_q <= k_q + 6'd1;
							mph_q <= 2'd0;
							state_q <= ST_MUL;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> state_q == ST_IDLE)
		else $error("ready outside idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("result dropped under stall");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CORD) |-> !s_axis_tready)
		else $error("accepting during CORDIC");
endmodule
